FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers on clk and rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ATDT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ATDT_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/atdt_pkg.sv
// ----------------------------------------------------------------------------
// atdt_pkg
// types and constants shared by the detent tick blocks
// ----------------------------------------------------------------------------
package atdt_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int DEG_W           = 9;
  localparam int ADJ_W           = 10;
  localparam int NUM_W           = 11;
  localparam int DETENT_W        = 10;
  localparam int COUNT_W         = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 9;

  localparam logic [DEG_W-1:0]        FULL_TURN = 9'd360;
  localparam logic signed [ADJ_W-1:0] HALF_POS  = 10'sd180;
  localparam logic signed [ADJ_W-1:0] HALF_NEG  = -10'sd180;
  localparam logic signed [ADJ_W-1:0] TURN_S    = 10'sd360;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_UP_TICK   = 3'd1,
    EV_DOWN_TICK = 3'd2,
    EV_UP_CONT   = 3'd3,
    EV_DOWN_CONT = 3'd4
  } ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE      = 3'd0,
    REG_UP_DETENTS    = 3'd1,
    REG_DOWN_DETENTS  = 3'd2,
    REG_UP_OFFSET     = 3'd3,
    REG_DOWN_OFFSET   = 3'd4,
    REG_UP_DISCRETE   = 3'd5,
    REG_DOWN_DISCRETE = 3'd6
  } reg_idx_t;

  // detent counts are already clamped to 1..360
  typedef struct packed {
    logic [7:0]       deadzone;
    logic [DEG_W-1:0] up_detents;
    logic [DEG_W-1:0] down_detents;
    logic [DEG_W-1:0] up_offset;
    logic [DEG_W-1:0] down_offset;
    logic             up_discrete;
    logic             down_discrete;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEG_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: hdl/angle_in_if.sv
// ----------------------------------------------------------------------------
// angle_in_if
// request channel carrying one raw angle sample
// ----------------------------------------------------------------------------
interface angle_in_if
  import atdt_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_angle;

  modport source (output valid, output raw_angle, input ready);
  modport sink   (input valid, input raw_angle, output ready);
endinterface

FILE: hdl/tick_out_if.sv
// ----------------------------------------------------------------------------
// tick_out_if
// result channel carrying the event and the position state
// ----------------------------------------------------------------------------
interface tick_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [8:0]  degrees;
  logic [31:0] position_count;
  logic [9:0]  detent_index;

  modport source (output valid, output event_res, output degrees, output position_count,
                  output detent_index, input ready);
  modport sink   (input valid, input event_res, input degrees, input position_count,
                  input detent_index, output ready);
endinterface

FILE: hdl/atdt_cfg_if.sv
// ----------------------------------------------------------------------------
// atdt_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface atdt_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [8:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/angle_to_detent_ticks.sv
// ----------------------------------------------------------------------------
// angle_to_detent_ticks
// magnetic angle to detent tick and continuous rotation events
// ----------------------------------------------------------------------------
// One sample is taken at a time and gives exactly one result. A sample that
// moves in no direction or in a continuous one goes from the scale state
// through the move and direction states to the done state; a sample that
// moves in a discrete direction passes in between through the step and
// index states, two passes through the shared 11-bit restoring divider
// (detent step, then detent index), one quotient bit per cycle. The input
// is ready again once the result sits in the output register, so a result
// left waiting holds the block.
`include "assert_macros.svh"

module angle_to_detent_ticks
  import atdt_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  angle_in_if.sink    in_ch,
  tick_out_if.source  out_ch,
  atdt_cfg_if.sink    cfg_ch
);

  localparam int PROD_W = SAMPLE_BITS + DEG_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCALE = 7'b0000010,
    ST_MOVE  = 7'b0000100,
    ST_DIR   = 7'b0001000,
    ST_STEP  = 7'b0010000,
    ST_INDEX = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  cfg_t                    cfg;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic [SAMPLE_BITS-1:0]  raw_r;
  logic [DEG_W-1:0]        deg_r;
  logic [DEG_W-1:0]        last_deg_r;
  logic [COUNT_W-1:0]      count_r;
  logic [COUNT_W-1:0]      prev_count_r;
  logic [DETENT_W-1:0]     last_detent_r;
  logic                    dir_up_r;
  ev_t                     event_r;

  logic                    out_valid_r;
  ev_t                     out_event_r;
  logic [DEG_W-1:0]        out_deg_r;
  logic [COUNT_W-1:0]      out_count_r;
  logic [DETENT_W-1:0]     out_detent_r;

  logic [PROD_W-1:0]       prod;
  logic signed [ADJ_W-1:0] delta_raw;
  logic signed [ADJ_W-1:0] delta;
  logic [ADJ_W-1:0]        mag;
  logic                    moved_ok;
  logic [COUNT_W-1:0]      count_diff;
  logic                    go_up;
  logic                    go_down;
  logic                    discrete;
  logic [DEG_W-1:0]        eff_detents;
  logic [DEG_W-1:0]        offset;
  logic [NUM_W-1:0]        adj;
  logic [DETENT_W-1:0]     quot_idx;
  logic                    out_load;

  atdt_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  atdt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == ST_IDLE);

  // degree scaling and wrapped change
  assign prod      = {{DEG_W{1'b0}}, raw_r} * PROD_W'(FULL_TURN);
  assign delta_raw = $signed({1'b0, deg_r}) - $signed({1'b0, last_deg_r});

  always_comb begin
    delta = delta_raw;
    if (delta_raw > HALF_POS) delta = delta_raw - TURN_S;
    else if (delta_raw < HALF_NEG) delta = delta_raw + TURN_S;
  end

  assign mag      = delta[ADJ_W-1] ? ADJ_W'(-delta) : ADJ_W'(delta);
  assign moved_ok = mag >= {2'b00, cfg.deadzone};

  assign count_diff = prev_count_r - count_r;
  assign go_up      = (count_diff != '0) && !count_diff[COUNT_W-1];
  assign go_down    = count_diff[COUNT_W-1];
  assign discrete   = go_up ? cfg.up_discrete : cfg.down_discrete;

  assign eff_detents = dir_up_r ? cfg.up_detents : cfg.down_detents;
  assign offset      = dir_up_r ? cfg.up_offset : cfg.down_offset;
  assign adj         = {2'b00, deg_r} + {3'b000, div_rsp.quot[DEG_W-1:1]} + {2'b00, offset};
  assign quot_idx    = div_rsp.quot[DETENT_W-1:0];

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = {2'b00, FULL_TURN};
    div_req.den   = eff_detents;
    if (state_r == ST_DIR && (go_up || go_down) && discrete) begin
      div_req.start = 1'b1;
      div_req.den   = go_up ? cfg.up_detents : cfg.down_detents;
    end else if (state_r == ST_STEP && div_rsp.done) begin
      div_req.start = 1'b1;
      div_req.num   = adj;
      div_req.den   = div_rsp.quot[DEG_W-1:0];
    end
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_MOVE;
      ST_MOVE:  state_nxt = ST_DIR;
      ST_DIR:   state_nxt = ((go_up || go_down) && discrete) ? ST_STEP : ST_DONE;
      ST_STEP:  if (div_rsp.done) state_nxt = ST_INDEX;
      ST_INDEX: if (div_rsp.done) state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      last_deg_r    <= '0;
      count_r       <= '0;
      prev_count_r  <= '0;
      last_detent_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_MOVE && moved_ok) begin
        count_r    <= count_r + {{(COUNT_W-ADJ_W){delta[ADJ_W-1]}}, delta};
        last_deg_r <= deg_r;
      end
      if (state_r == ST_DIR && (go_up || go_down)) begin
        prev_count_r <= count_r;
      end
      if (state_r == ST_INDEX && div_rsp.done &&
          quot_idx != last_detent_r && quot_idx != {1'b0, eff_detents}) begin
        last_detent_r <= quot_idx;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) raw_r <= in_ch.raw_angle[SAMPLE_BITS-1:0];
    if (state_r == ST_SCALE) deg_r <= prod[PROD_W-1:SAMPLE_BITS];
    if (state_r == ST_DIR) begin
      dir_up_r <= go_up;
      if (go_up || go_down) begin
        if (discrete) event_r <= EV_NONE;
        else event_r <= go_up ? EV_UP_CONT : EV_DOWN_CONT;
      end else begin
        event_r <= EV_NONE;
      end
    end
    if (state_r == ST_INDEX && div_rsp.done) begin
      if (quot_idx != last_detent_r && quot_idx != {1'b0, eff_detents}) begin
        event_r <= dir_up_r ? EV_UP_TICK : EV_DOWN_TICK;
      end else begin
        event_r <= EV_NONE;
      end
    end
    if (out_load) begin
      out_event_r  <= event_r;
      out_deg_r    <= deg_r;
      out_count_r  <= count_r;
      out_detent_r <= last_detent_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_res      = out_event_r;
  assign out_ch.degrees        = out_deg_r;
  assign out_ch.position_count = out_count_r;
  assign out_ch.detent_index   = out_detent_r;

  `ATDT_ASSERT(a_one_request, in_ch.valid && in_ch.ready |=> !in_ch.ready,
               "second request taken while busy")
  `ATDT_ASSERT(a_out_from_done, $rose(out_valid_r) |-> $past(state_r == ST_DONE),
               "result raised outside the done state")
  `ATDT_ASSERT(a_div_owner, div_rsp.done |-> (state_r == ST_STEP || state_r == ST_INDEX),
               "divider result with no division pending")
  `ATDT_ASSERT_NR(a_reset_clears, !rst_n |=> !out_valid_r && in_ch.ready,
                  "reset left a result or a busy sequencer")

endmodule

FILE: hdl/atdt_cfg.sv
// ----------------------------------------------------------------------------
// atdt_cfg
// configuration register file with detent count clamping
// ----------------------------------------------------------------------------
module atdt_cfg
  import atdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  atdt_cfg_if.sink    cfg_ch,
  output cfg_t        cfg
);

  logic [7:0]       deadzone_r;
  logic [DEG_W-1:0] up_detents_r;
  logic [DEG_W-1:0] down_detents_r;
  logic [DEG_W-1:0] up_offset_r;
  logic [DEG_W-1:0] down_offset_r;
  logic             up_discrete_r;
  logic             down_discrete_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r      <= 8'd1;
      up_detents_r    <= 9'd24;
      down_detents_r  <= 9'd24;
      up_offset_r     <= '0;
      down_offset_r   <= '0;
      up_discrete_r   <= 1'b1;
      down_discrete_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_DEADZONE:      deadzone_r      <= cfg_ch.data[7:0];
        REG_UP_DETENTS:    up_detents_r    <= cfg_ch.data;
        REG_DOWN_DETENTS:  down_detents_r  <= cfg_ch.data;
        REG_UP_OFFSET:     up_offset_r     <= cfg_ch.data;
        REG_DOWN_OFFSET:   down_offset_r   <= cfg_ch.data;
        REG_UP_DISCRETE:   up_discrete_r   <= cfg_ch.data[0];
        REG_DOWN_DISCRETE: down_discrete_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  function automatic logic [DEG_W-1:0] clamp_detents(input logic [DEG_W-1:0] d);
    logic [DEG_W-1:0] r;
    r = d;
    if (d == '0) r = DEG_W'(1);
    else if (d > FULL_TURN) r = FULL_TURN;
    return r;
  endfunction

  always_comb begin
    cfg.deadzone      = deadzone_r;
    cfg.up_detents    = clamp_detents(up_detents_r);
    cfg.down_detents  = clamp_detents(down_detents_r);
    cfg.up_offset     = up_offset_r;
    cfg.down_offset   = down_offset_r;
    cfg.up_discrete   = up_discrete_r;
    cfg.down_discrete = down_discrete_r;
  end

endmodule

FILE: hdl/atdt_div.sv
// ----------------------------------------------------------------------------
// atdt_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module atdt_div
  import atdt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] q_r;
  logic [DEG_W-1:0] rem_r;
  logic [DEG_W-1:0] den_r;

  logic [DEG_W:0]   trial;
  logic             ge;
  logic [DEG_W:0]   diff;

  assign trial = {rem_r, q_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      q_r   <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEG_W-1:0] : trial[DEG_W-1:0];
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;

  `ATDT_ASSERT(a_div_no_restart, req.start |-> !busy_r, "divider started while busy")

endmodule

FILE: dv/tb_angle_to_detent_ticks.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_angle_to_detent_ticks
// self-checking bench for the angle to detent tick block: a short table of
// directed samples and register writes, then random walks of the angle under
// several register settings, with the sender and receiver pacing varied per
// phase; every result is compared with a typed-in or built-in prediction
// of the block
module tb_angle_to_detent_ticks;
  import atdt_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 5000;
  localparam int BLOCKS       = 9;
  localparam int BLOCK_ITEMS  = 70;

  typedef struct packed {
    ev_t         ev;
    logic [8:0]  deg;
    logic [31:0] pos;
    logic [9:0]  det;
  } angle_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    reg_idx_t      idx;
    logic [11:0]   value;
    logic          typed;
    angle_result_t want;
  } row_t;

  logic clk;
  logic rst_n;

  angle_in_if #(.SAMPLE_BITS(12)) in_ch ();
  tick_out_if                     out_ch ();
  atdt_cfg_if                     cfg_ch ();

  angle_to_detent_ticks dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // settings and state as the block should hold them
  logic [7:0]  dz_cfg;
  logic [8:0]  up_det, dn_det, up_off, dn_off;
  logic        up_disc, dn_disc;
  logic [8:0]  held_deg;
  logic [31:0] turn_count, prev_turn_count;
  logic [9:0]  held_detent;

  angle_result_t pending_results [$];
  angle_result_t head;
  logic [8:0]    next_regs [0:6];
  logic [11:0]   angle_now;
  int            send_gap, recv_stall;
  int            fails = 0;
  int            quiet_cycles = 0;

  // directed samples and writes, expectations typed in only for the opening rows
  row_t plan [0:25] = '{
    '{ROW_ITEM, REG_DEADZONE,      12'd0,    1'b1, '{EV_NONE, 9'd0,   32'd0,          10'd0}},
    '{ROW_ITEM, REG_DEADZONE,      12'd4095, 1'b1, '{EV_NONE, 9'd359, 32'hFFFF_FFFF,  10'd0}},
    '{ROW_ITEM, REG_DEADZONE,      12'd2048, 1'b0, '0},
    '{ROW_ITEM, REG_DEADZONE,      12'd2059, 1'b0, '0},
    '{ROW_ITEM, REG_DEADZONE,      12'd1024, 1'b0, '0},
    '{ROW_ITEM, REG_DEADZONE,      12'd3072, 1'b0, '0},
    '{ROW_CFG,  REG_DEADZONE,      12'd0,    1'b0, '0},
    '{ROW_ITEM, REG_DEADZONE,      12'd3072, 1'b0, '0},
    '{ROW_ITEM, REG_DEADZONE,      12'd3084, 1'b0, '0},
    '{ROW_CFG,  REG_UP_DETENTS,    12'd0,    1'b0, '0},
    '{ROW_ITEM, REG_DEADZONE,      12'd2900, 1'b0, '0},
    '{ROW_CFG,  REG_DOWN_DETENTS,  12'd511,  1'b0, '0},
    '{ROW_ITEM, REG_DEADZONE,      12'd4000, 1'b0, '0},
    '{ROW_CFG,  REG_DOWN_OFFSET,   12'd511,  1'b0, '0},
    '{ROW_ITEM, REG_DEADZONE,      12'd4095, 1'b0, '0},
    '{ROW_CFG,  REG_UP_OFFSET,     12'd359,  1'b0, '0},
    '{ROW_CFG,  REG_UP_DISCRETE,   12'd0,    1'b0, '0},
    '{ROW_ITEM, REG_DEADZONE,      12'd2048, 1'b0, '0},
    '{ROW_CFG,  REG_DOWN_DISCRETE, 12'd0,    1'b0, '0},
    '{ROW_ITEM, REG_DEADZONE,      12'd3500, 1'b0, '0},
    '{ROW_CFG,  REG_DEADZONE,      12'd255,  1'b0, '0},
    '{ROW_ITEM, REG_DEADZONE,      12'd0,    1'b0, '0},
    '{ROW_ITEM, REG_DEADZONE,      12'd2048, 1'b0, '0},
    '{ROW_CFG,  REG_DEADZONE,      12'd180,  1'b0, '0},
    '{ROW_ITEM, REG_DEADZONE,      12'd1445, 1'b0, '0},
    '{ROW_ITEM, REG_DEADZONE,      12'd2048, 1'b0, '0}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [9:0] detent_of(input int unsigned deg, input logic [8:0] det,
                                           input logic [8:0] off, output int unsigned eff);
    int unsigned d, pitch;
    d = det;
    if (d == 0) d = 1;
    if (d > 360) d = 360;
    eff   = d;
    pitch = 360 / d;
    return 10'((deg + pitch / 2 + off) / pitch);
  endfunction

  function automatic angle_result_t track_angle(input logic [11:0] raw);
    angle_result_t res;
    int unsigned   deg, eff;
    int            delta, mag;
    logic [31:0]   moved;
    logic          go_up, go_down, discrete;
    logic [9:0]    idx;
    deg    = (32'(raw) * 360) >> 12;
    res.ev = EV_NONE;
    delta  = int'(deg) - int'(held_deg);
    if (delta > 180) delta -= 360;
    else if (delta < -180) delta += 360;
    mag = (delta < 0) ? -delta : delta;
    if (mag >= int'(dz_cfg)) begin
      turn_count = turn_count + delta;
      held_deg   = deg[8:0];
      moved      = prev_turn_count - turn_count;
      go_up      = (moved != 0) && !moved[31];
      go_down    = moved[31];
      if (go_up || go_down) begin
        discrete = go_up ? up_disc : dn_disc;
        if (discrete) begin
          if (go_up) idx = detent_of(deg, up_det, up_off, eff);
          else idx = detent_of(deg, dn_det, dn_off, eff);
          if (idx != held_detent && 32'(idx) != eff) begin
            if (go_up) res.ev = EV_UP_TICK;
            else res.ev = EV_DOWN_TICK;
            held_detent = idx;
          end
        end else if (go_up) begin
          res.ev = EV_UP_CONT;
        end else begin
          res.ev = EV_DOWN_CONT;
        end
        prev_turn_count = turn_count;
      end
    end
    res.deg = deg[8:0];
    res.pos = turn_count;
    res.det = held_detent;
    return res;
  endfunction

  function automatic void apply_reg(input reg_idx_t idx, input logic [8:0] val);
    case (idx)
      REG_DEADZONE:      dz_cfg  = val[7:0];
      REG_UP_DETENTS:    up_det  = val;
      REG_DOWN_DETENTS:  dn_det  = val;
      REG_UP_OFFSET:     up_off  = val;
      REG_DOWN_OFFSET:   dn_off  = val;
      REG_UP_DISCRETE:   up_disc = val[0];
      REG_DOWN_DISCRETE: dn_disc = val[0];
      default: ;
    endcase
  endfunction

  function automatic logic [8:0] pick_detents();
    case ($urandom_range(9))
      0:       return 9'd0;
      1:       return 9'd1;
      2:       return 9'd360;
      3:       return 9'($urandom_range(361, 511));
      4:       return 9'd2;
      5, 6:    return 9'd24;
      default: return 9'($urandom_range(1, 360));
    endcase
  endfunction

  function automatic logic [8:0] pick_offset();
    case ($urandom_range(5))
      0:       return 9'd0;
      1:       return 9'd359;
      2:       return 9'd511;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic [8:0] pick_mode();
    logic [8:0] m;
    m = 9'($urandom_range(0, 511));
    if ($urandom_range(3) != 0) m[0] = 1'b1;
    return m;
  endfunction

  task automatic send_angle(input logic [11:0] raw);
    while ($urandom_range(99) < send_gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.raw_angle <= raw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic feed_angle(input logic [11:0] raw, input logic typed, input angle_result_t want);
    angle_result_t got;
    send_angle(raw);
    got = track_angle(raw);
    pending_results.push_back(typed ? want : got);
  endtask

  // block drained and quiet before any register write
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input int first, input int last);
    for (int i = first; i <= last; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= reg_idx_t'(i);
      cfg_ch.data  <= next_regs[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      apply_reg(reg_idx_t'(i), next_regs[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic new_settings();
    case ($urandom_range(11))
      0:       next_regs[REG_DEADZONE] = 9'd0;
      1:       next_regs[REG_DEADZONE] = 9'd180;
      2:       next_regs[REG_DEADZONE] = 9'd255;
      3:       next_regs[REG_DEADZONE] = {1'b1, 8'($urandom_range(0, 5))};
      default: next_regs[REG_DEADZONE] = 9'($urandom_range(1, 6));
    endcase
    next_regs[REG_UP_DETENTS]    = pick_detents();
    next_regs[REG_DOWN_DETENTS]  = pick_detents();
    next_regs[REG_UP_OFFSET]     = pick_offset();
    next_regs[REG_DOWN_OFFSET]   = pick_offset();
    next_regs[REG_UP_DISCRETE]   = pick_mode();
    next_regs[REG_DOWN_DISCRETE] = pick_mode();
    settle();
    program_regs(int'(REG_DEADZONE), int'(REG_DOWN_DISCRETE));
  endtask

  // mostly a turning knob, some jitter near the deadzone, some jumps and noise
  task automatic walk_angle();
    int pick, step;
    pick = $urandom_range(99);
    step = 0;
    if (pick < 70) step = int'($urandom_range(0, 500)) - 250;
    else if (pick < 85) step = int'($urandom_range(0, 50)) - 25;
    else if (pick < 95) angle_now = 12'($urandom_range(0, 4095));
    else step = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(2000, 2100));
    angle_now = angle_now + 12'(step);
    feed_angle(angle_now, 1'b0, '0);
  endtask

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending, ev=%0d deg=%0d",
                 $time, out_ch.event_res, out_ch.degrees);
        fails++;
      end else begin
        head = pending_results.pop_front();
        if (out_ch.event_res !== head.ev || out_ch.degrees !== head.deg ||
            out_ch.position_count !== head.pos || out_ch.detent_index !== head.det) begin
          $display("%0t: ev/deg/pos/det expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                   $time, head.ev, head.deg, $signed(head.pos), head.det,
                   out_ch.event_res, out_ch.degrees, $signed(out_ch.position_count),
                   out_ch.detent_index);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress, %0d results outstanding", $time, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.raw_angle  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_DEADZONE;
    cfg_ch.data      = '0;
    angle_now        = '0;
    send_gap         = 13;
    recv_stall       = 86;
    dz_cfg           = 8'd1;
    up_det           = 9'd24;
    dn_det           = 9'd24;
    up_off           = '0;
    dn_off           = '0;
    up_disc          = 1'b1;
    dn_disc          = 1'b1;
    held_deg         = '0;
    turn_count       = '0;
    prev_turn_count  = '0;
    held_detent      = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 26; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        next_regs[plan[i].idx] = plan[i].value[8:0];
        program_regs(int'(plan[i].idx), int'(plan[i].idx));
      end else begin
        feed_angle(plan[i].value, plan[i].typed, plan[i].want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_gap = 13; recv_stall = 86; end
        1:       begin send_gap = 86; recv_stall = 13; end
        default: begin send_gap = 0;  recv_stall = 0;  end
      endcase
      for (int blk = 0; blk < BLOCKS; blk++) begin
        new_settings();
        for (int n = 0; n < BLOCK_ITEMS; n++) walk_angle();
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: angle_to_detent_ticks.f
+incdir+hdl
hdl/atdt_pkg.sv
hdl/angle_in_if.sv
hdl/tick_out_if.sv
hdl/atdt_cfg_if.sv
hdl/atdt_cfg.sv
hdl/atdt_div.sv
hdl/angle_to_detent_ticks.sv
dv/tb_angle_to_detent_ticks.sv
